FILE: src/pmpc_pkg.sv
// ============================================================================
// PID motor position controller package
// Shared types, widths, register indexes and reset values for the controller.
// ============================================================================
`default_nettype none

package pmpc_pkg;

    // Field and datapath widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned VEL_W      = 8;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned PRESC_W    = 8;
    localparam int unsigned GUARD_W    = 24;
    localparam int unsigned INTEG_W    = 25;
    localparam int unsigned DERIV_W    = 33;
    localparam int unsigned ACC_W      = 34;
    localparam int unsigned PLIM_W     = 32;
    localparam int unsigned P_PROD_W   = 48;
    localparam int unsigned I_PROD_W   = 41;
    localparam int unsigned D_PROD_W   = 49;
    localparam int unsigned SUM_W      = 51;
    localparam int unsigned DRIVE_W    = 17;
    localparam int unsigned MATCH_W    = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PGAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IGAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DGAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PGUARD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IGUARD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PWM_LIM = 3'd6;

    // Register values after reset.
    localparam logic signed [GAIN_W-1:0] RST_PGAIN     = 16'sd80;
    localparam logic signed [GAIN_W-1:0] RST_IGAIN     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_DGAIN     = 16'sd0;
    localparam logic [PRESC_W-1:0]       RST_PRESC     = 8'd20;
    localparam logic [GUARD_W-1:0]       RST_PGUARD    = 24'd2400;
    localparam logic [GUARD_W-1:0]       RST_IGUARD    = 24'd960;
    localparam logic [PLIM_W-1:0]        RST_PWM_LIMIT = 32'd9600;

    typedef enum logic [1:0] {
        DIR_BRAKE   = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef struct packed {
        logic signed [POS_W-1:0] measured_position;
        logic signed [VEL_W-1:0] requested_velocity;
        logic                    resync;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_width;
        dir_t                      direction;
        logic [MATCH_W-1:0]        match_value;
        logic signed [POS_W-1:0]   position_error;
    } out_item_t;

    // Current configuration; pwm_limit is zero-extended from its stored width.
    typedef struct packed {
        logic signed [GAIN_W-1:0] proportional_gain;
        logic signed [GAIN_W-1:0] integral_gain;
        logic signed [GAIN_W-1:0] derivative_gain;
        logic [PRESC_W-1:0]       velocity_prescaler;
        logic [GUARD_W-1:0]       position_guard;
        logic [GUARD_W-1:0]       integral_guard;
        logic [PLIM_W-1:0]        pwm_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   err;
        logic signed [INTEG_W-1:0] integral;
        logic signed [DERIV_W-1:0] deriv;
    } err_stage_t;

    typedef struct packed {
        logic signed [P_PROD_W-1:0] p_term;
        logic signed [I_PROD_W-1:0] i_term;
        logic signed [D_PROD_W-1:0] d_term;
        logic signed [POS_W-1:0]    err;
    } prod_stage_t;

endpackage : pmpc_pkg

`default_nettype wire

FILE: src/pmpc_cfg_regs.sv
// ============================================================================
// PID controller configuration registers
// Holds gains, prescaler reload, guards and PWM limit written over the
// configuration channel.
// ============================================================================
`default_nettype none

module pmpc_cfg_regs
    import pmpc_pkg::*;
#(
    parameter int unsigned PWM_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    localparam logic [PWM_WIDTH-1:0] PWM_LIMIT_RST = PWM_WIDTH'(RST_PWM_LIMIT);

    logic signed [GAIN_W-1:0] pgain_reg, pgain_next;
    logic signed [GAIN_W-1:0] igain_reg, igain_next;
    logic signed [GAIN_W-1:0] dgain_reg, dgain_next;
    logic [PRESC_W-1:0]       presc_reg, presc_next;
    logic [GUARD_W-1:0]       pguard_reg, pguard_next;
    logic [GUARD_W-1:0]       iguard_reg, iguard_next;
    logic [PWM_WIDTH-1:0]     pwm_limit_reg, pwm_limit_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        pgain_next     = pgain_reg;
        igain_next     = igain_reg;
        dgain_next     = dgain_reg;
        presc_next     = presc_reg;
        pguard_next    = pguard_reg;
        iguard_next    = iguard_reg;
        pwm_limit_next = pwm_limit_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_PGAIN:   pgain_next     = $signed(cfg_data[GAIN_W-1:0]);
                CFG_IDX_IGAIN:   igain_next     = $signed(cfg_data[GAIN_W-1:0]);
                CFG_IDX_DGAIN:   dgain_next     = $signed(cfg_data[GAIN_W-1:0]);
                CFG_IDX_PRESC:   presc_next     = cfg_data[PRESC_W-1:0];
                CFG_IDX_PGUARD:  pguard_next    = cfg_data[GUARD_W-1:0];
                CFG_IDX_IGUARD:  iguard_next    = cfg_data[GUARD_W-1:0];
                CFG_IDX_PWM_LIM: pwm_limit_next = cfg_data[PWM_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pgain_reg     <= RST_PGAIN;
            igain_reg     <= RST_IGAIN;
            dgain_reg     <= RST_DGAIN;
            presc_reg     <= RST_PRESC;
            pguard_reg    <= RST_PGUARD;
            iguard_reg    <= RST_IGUARD;
            pwm_limit_reg <= PWM_LIMIT_RST;
        end else begin
            pgain_reg     <= pgain_next;
            igain_reg     <= igain_next;
            dgain_reg     <= dgain_next;
            presc_reg     <= presc_next;
            pguard_reg    <= pguard_next;
            iguard_reg    <= iguard_next;
            pwm_limit_reg <= pwm_limit_next;
        end
    end

    always_comb begin
        cfg.proportional_gain  = pgain_reg;
        cfg.integral_gain      = igain_reg;
        cfg.derivative_gain    = dgain_reg;
        cfg.velocity_prescaler = presc_reg;
        cfg.position_guard     = pguard_reg;
        cfg.integral_guard     = iguard_reg;
        cfg.pwm_limit          = PLIM_W'(pwm_limit_reg);
    end

endmodule : pmpc_cfg_regs

`default_nettype wire

FILE: src/pmpc_state_update.sv
// ============================================================================
// PID controller state update stage
// Advances the target, forms the error, applies the position guard, updates
// the clamped integral and the derivative, and registers them.
// ============================================================================
`default_nettype none

module pmpc_state_update
    import pmpc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output err_stage_t    out_item
);

    logic [POS_W-1:0]          target_reg, target_next;
    logic [PRESC_W-1:0]        presc_reg, presc_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [POS_W-1:0]   prev_err_reg, prev_err_next;
    logic                      a_valid_reg, a_valid_next;
    err_stage_t                a_item_reg;

    logic                      fire;
    logic                      presc_zero;
    logic [POS_W-1:0]          meas_u;
    logic [POS_W-1:0]          tgt_base;
    logic [POS_W-1:0]          tgt_adv;
    logic [POS_W-1:0]          pguard_u;
    logic signed [POS_W-1:0]   err;
    logic signed [DERIV_W-1:0] err_ext;
    logic signed [DERIV_W-1:0] pguard_ext;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ACC_W-1:0]   iguard_ext;
    logic signed [ACC_W-1:0]   integ_clamped;
    err_stage_t                a_item_next;

    assign in_ready = !a_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        meas_u     = in_item.measured_position;
        pguard_u   = POS_W'(cfg.position_guard);
        presc_zero = (presc_reg == '0);
        tgt_base   = in_item.resync ? meas_u : target_reg;
        tgt_adv    = presc_zero ? tgt_base + POS_W'(in_item.requested_velocity) : tgt_base;
        err        = $signed(tgt_adv - meas_u);
        err_ext    = DERIV_W'(err);
        pguard_ext = $signed(DERIV_W'(cfg.position_guard));

        integ_sum  = ACC_W'(integ_reg) + ACC_W'(err);
        iguard_ext = $signed(ACC_W'(cfg.integral_guard));
        if (integ_sum > iguard_ext) begin
            integ_clamped = iguard_ext;
        end else if (integ_sum < -iguard_ext) begin
            integ_clamped = -iguard_ext;
        end else begin
            integ_clamped = integ_sum;
        end

        deriv = err_ext - DERIV_W'(prev_err_reg);

        a_item_next.err      = err;
        a_item_next.integral = INTEG_W'(integ_clamped);
        a_item_next.deriv    = deriv;
    end

    always_comb begin
        target_next   = target_reg;
        presc_next    = presc_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        a_valid_next  = a_valid_reg;
        if (in_ready) begin
            a_valid_next = in_valid;
        end
        if (fire) begin
            presc_next = presc_zero ? cfg.velocity_prescaler : presc_reg - 1'b1;
            // The guard pulls the stored target back; this tick's error is kept as is.
            if (err_ext > pguard_ext) begin
                target_next = meas_u + pguard_u;
            end else if (err_ext < -pguard_ext) begin
                target_next = meas_u - pguard_u;
            end else begin
                target_next = tgt_adv;
            end
            integ_next    = a_item_next.integral;
            prev_err_next = err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            presc_reg    <= '0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            a_valid_reg  <= 1'b0;
        end else begin
            target_reg   <= target_next;
            presc_reg    <= presc_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            a_valid_reg  <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            a_item_reg <= a_item_next;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_item  = a_item_reg;

    a_presc_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire && !presc_zero |=> presc_reg == PRESC_W'($past(presc_reg) - 1'b1))
        else $error("prescaler did not count down by one");

    a_presc_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire && presc_zero |=> presc_reg == $past(cfg.velocity_prescaler))
        else $error("prescaler did not reload on rollover");

    a_prev_err_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire |=> prev_err_reg == a_item_reg.err)
        else $error("previous error differs from the registered error");

endmodule : pmpc_state_update

`default_nettype wire

FILE: src/pmpc_mult.sv
// ============================================================================
// PID controller multiplier stage
// Forms the P, I and D products and registers them.
// ============================================================================
`default_nettype none

module pmpc_mult
    import pmpc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire err_stage_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output prod_stage_t     out_item
);

    logic        b_valid_reg, b_valid_next;
    prod_stage_t b_item_reg, b_item_next;
    logic        fire;

    assign in_ready = !b_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        b_item_next.p_term = P_PROD_W'(in_item.err) * P_PROD_W'(cfg.proportional_gain);
        b_item_next.i_term = I_PROD_W'(in_item.integral) * I_PROD_W'(cfg.integral_gain);
        b_item_next.d_term = D_PROD_W'(in_item.deriv) * D_PROD_W'(cfg.derivative_gain);
        b_item_next.err    = in_item.err;
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (in_ready) begin
            b_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule : pmpc_mult

`default_nettype wire

FILE: src/pmpc_sum_sat.sv
// ============================================================================
// PID controller sum and output stage
// Adds the three terms, then saturates to the PWM limit and forms the
// drive width, bridge direction and compare value in the result register.
// ============================================================================
`default_nettype none

module pmpc_sum_sat
    import pmpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire prod_stage_t in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item
);

    logic                    c_valid_reg, c_valid_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [POS_W-1:0] c_err_reg;
    logic                    o_valid_reg, o_valid_next;
    out_item_t               o_item_reg, o_item_next;

    logic                    c_ready;
    logic                    c_fire;
    logic                    o_fire;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] sat;
    logic signed [SUM_W-1:0] match_wide;

    assign o_fire   = c_valid_reg && c_ready;
    assign c_ready  = !o_valid_reg || out_ready;
    assign in_ready = !c_valid_reg || c_ready;
    assign c_fire   = in_valid && in_ready;

    always_comb begin
        sum_next = SUM_W'(in_item.p_term) + SUM_W'(in_item.i_term) + SUM_W'(in_item.d_term);
    end

    always_comb begin
        lim = $signed(SUM_W'(cfg.pwm_limit));
        if (sum_reg > lim) begin
            sat = lim;
        end else if (sum_reg < -lim) begin
            sat = -lim;
        end else begin
            sat = sum_reg;
        end

        if (sat > 0) begin
            o_item_next.direction = DIR_FORWARD;
            match_wide            = lim - sat;
        end else if (sat < 0) begin
            o_item_next.direction = DIR_REVERSE;
            match_wide            = -sat;
        end else begin
            o_item_next.direction = DIR_BRAKE;
            match_wide            = '0;
        end

        o_item_next.drive_width    = sat[DRIVE_W-1:0];
        o_item_next.match_value    = match_wide[MATCH_W-1:0];
        o_item_next.position_error = c_err_reg;
    end

    always_comb begin
        c_valid_next = c_valid_reg;
        o_valid_next = o_valid_reg;
        if (in_ready) begin
            c_valid_next = in_valid;
        end
        if (c_ready) begin
            o_valid_next = c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_fire) begin
            sum_reg   <= sum_next;
            c_err_reg <= in_item.err;
        end
        if (o_fire) begin
            o_item_reg <= o_item_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

endmodule : pmpc_sum_sat

`default_nettype wire

FILE: src/pid_motor_position_controller.sv
// ============================================================================
// PID motor position controller
// Per control tick: advances the target position, forms the position error,
// applies position and integral guards, and saturates P + I + D to the PWM
// limit to give drive width, H-bridge direction and PWM compare value.
// ============================================================================
// Registers in order: input register, state update, multipliers, sum, result.
// Throughput: one transaction per cycle while the result channel is not
// stalled by m_ready; the target, integral and previous error recurrence
// closes within the single state update stage.
// Reset: synchronous, active low; state clears to zero and the configuration
// registers return to their defaults (gains 80/0/0, prescaler 20, guards
// 2400/960, PWM limit 9600).
`default_nettype none

module pid_motor_position_controller
    import pmpc_pkg::*;
#(
    parameter int unsigned PWM_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input channel: one control tick per transaction.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // Result channel: one result per tick.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg;

    // The input register decouples the state update logic from the port.
    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic        s_fire;

    logic        a_in_ready;
    logic        a_valid;
    err_stage_t  a_item;
    logic        b_in_ready;
    logic        b_valid;
    prod_stage_t b_item;
    logic        c_in_ready;

    pmpc_cfg_regs #(
        .PWM_WIDTH (PWM_WIDTH)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A transaction enters whenever the input register is empty or is being
    // drained into the state update stage in the same cycle.
    assign s_ready = !in_valid_reg || a_in_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_data;
        end
    end

    // Stage A: target, prescaler, error, integral and derivative. All of the
    // controller state lives here and updates once per transaction.
    pmpc_state_update u_state_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (a_in_ready),
        .in_item   (in_item_reg),
        .out_valid (a_valid),
        .out_ready (b_in_ready),
        .out_item  (a_item)
    );

    // Stage B: the three gain products, each registered.
    pmpc_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (a_valid),
        .in_ready  (b_in_ready),
        .in_item   (a_item),
        .out_valid (b_valid),
        .out_ready (c_in_ready),
        .out_item  (b_item)
    );

    // Stages C and D: full-width sum, then saturation and PWM mapping into
    // the result register that drives the output channel.
    pmpc_sum_sat u_sum_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (b_valid),
        .in_ready  (c_in_ready),
        .in_item   (b_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

    a_brake_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.direction == DIR_BRAKE |->
            m_data.drive_width == '0 && m_data.match_value == '0)
        else $error("brake result carries a nonzero width or compare value");

    a_reverse_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.direction == DIR_REVERSE |->
            m_data.match_value == MATCH_W'(-m_data.drive_width))
        else $error("reverse compare value is not the drive magnitude");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stalled while the input register is empty");

endmodule : pid_motor_position_controller

`default_nettype wire
